// ===== rtl/vrq_pkg.sv =====
// Shared types, constants and helper functions of the virtual-runtime run queue scheduler.
// Has no dependencies; every other file of the block but vrq_ram imports it.
`default_nettype none

package vrq_pkg;

   localparam int RT_WIDTH           = 63;
   localparam int PRIO_WIDTH         = 2;
   localparam int SLICE_WIDTH        = 8;
   localparam int RUN_CNT_WIDTH      = 6;
   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_TASK_ID_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH     = 64;
   localparam int CSR_ADDR_WIDTH     = 4;

   // Register select: bit 3 of the byte address picks the 64-bit register.
   localparam logic REG_IDLE_RUNTIME  = 1'b0;
   localparam logic REG_IDLE_PRIORITY = 1'b1;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_WR,
      ST_DONE
   } vrq_state_type;

   typedef struct packed {
      logic [RT_WIDTH-1:0]   idle_runtime;
      logic [PRIO_WIDTH-1:0] idle_priority;
   } vrq_cfg_type;

   // New time slice: 4/count, times three above priority 1; a count of zero counts as one.
   function automatic logic [SLICE_WIDTH-1:0] slice_refill(
      input logic [RUN_CNT_WIDTH-1:0] count,
      input logic [PRIO_WIDTH-1:0]    prio
   );
      logic [SLICE_WIDTH-1:0] base;
      if (count <= RUN_CNT_WIDTH'(1)) begin
         base = SLICE_WIDTH'(4);
      end else if (count == RUN_CNT_WIDTH'(2)) begin
         base = SLICE_WIDTH'(2);
      end else if (count <= RUN_CNT_WIDTH'(4)) begin
         base = SLICE_WIDTH'(1);
      end else begin
         base = '0;
      end
      return (prio <= PRIO_WIDTH'(1)) ? base : SLICE_WIDTH'(base * SLICE_WIDTH'(3));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vruntime_run_queue_scheduler_unit.sv =====
// Top level of the virtual-runtime run queue scheduler: configuration registers and the
// run queue sequencer. Depends on vrq_pkg, vrq_csr, vrq_ctrl (and vrq_ram below it).
//
//   channel   ports                          handshake
//   request   req_*                          accepted when start is high and busy is low
//   result    rsp_*                          rsp_valid high for one cycle, always taken
//   config    psel penable pwrite paddr ...  APB write in setup and access cycles
//
// One item is in work at a time. An insert walks down from the tail in ST_INS_RD and ST_INS_WR,
// reading one RAM entry and writing it one slot up for each queued entry with a runtime not
// below the new one, then writes the new entry; an idle or dropped insert goes straight to
// ST_DONE. A schedule item pops the head in ST_POP (skipped on an empty queue), decides in
// ST_DECIDE and then walks the same way to requeue the task that was not picked, unless its
// id is zero or it is a stopped current task.
// Reset empties the queue at once; the queue memory needs no clearing pass.
// busy stays high through the result cycle; the next item is taken in the cycle after it.
`default_nettype none

module vruntime_run_queue_scheduler_unit
   import vrq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
   parameter int TASK_ID_WIDTH = DEF_TASK_ID_WIDTH,
   localparam int LEN_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire logic                      req_opcode,
   input  wire logic [TASK_ID_WIDTH-1:0]  req_task_id,
   input  wire logic [RT_WIDTH-1:0]       req_task_runtime,
   input  wire logic [PRIO_WIDTH-1:0]     req_task_priority,
   input  wire logic                      req_task_running,
   input  wire logic [SLICE_WIDTH-1:0]    req_slice_left,
   output      logic                      rsp_valid,
   output      logic [TASK_ID_WIDTH-1:0]  rsp_next_task_id,
   output      logic                      rsp_switched,
   output      logic [SLICE_WIDTH-1:0]    rsp_slice_value,
   output      logic [LEN_W-1:0]          rsp_queue_count,
   output      logic                      rsp_overflow,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready
);

   vrq_cfg_type cfg;

   vrq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vrq_ctrl #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .TASK_ID_WIDTH (TASK_ID_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_task_id       (req_task_id),
      .req_task_runtime  (req_task_runtime),
      .req_task_priority (req_task_priority),
      .req_task_running  (req_task_running),
      .req_slice_left    (req_slice_left),
      .rsp_valid         (rsp_valid),
      .rsp_next_task_id  (rsp_next_task_id),
      .rsp_switched      (rsp_switched),
      .rsp_slice_value   (rsp_slice_value),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_overflow      (rsp_overflow)
   );

   // An accepted item keeps the block busy until its result has been shown.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && !$past(rsp_valid))
      else $error("result shown outside an item or twice in a row");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= LEN_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // A dropped insert only happens on a full queue and never switches.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         !rsp_switched && (rsp_next_task_id == '0) &&
         (rsp_queue_count == LEN_W'(QUEUE_DEPTH)))
      else $error("overflow flagged on an item that could not overflow");

endmodule

`default_nettype wire

// ===== rtl/vrq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module vrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/vrq_csr.sv =====
// Configuration registers of the run queue scheduler behind an APB-style port.
// Depends on vrq_pkg.
`default_nettype none

module vrq_csr
   import vrq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready,
   output      vrq_cfg_type               cfg
);

   vrq_cfg_type cfg_ff, cfg_in;
   logic        reg_sel;
   logic        wr_en;

   assign reg_sel = paddr[CSR_ADDR_WIDTH-1];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_IDLE_RUNTIME:  cfg_in.idle_runtime  = pwdata[RT_WIDTH-1:0];
            REG_IDLE_PRIORITY: cfg_in.idle_priority = pwdata[PRIO_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IDLE_RUNTIME:  prdata = CSR_DATA_WIDTH'(cfg_ff.idle_runtime);
         REG_IDLE_PRIORITY: prdata = CSR_DATA_WIDTH'(cfg_ff.idle_priority);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vrq_ctrl.sv =====
// Sequencer and datapath of the run queue: a circular buffer in one RAM, kept sorted by an
// insertion walk from the tail. Depends on vrq_pkg and vrq_ram.
`default_nettype none

module vrq_ctrl
   import vrq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
   parameter int TASK_ID_WIDTH = DEF_TASK_ID_WIDTH,
   localparam int LEN_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vrq_cfg_type              cfg,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic                     req_opcode,
   input  wire logic [TASK_ID_WIDTH-1:0] req_task_id,
   input  wire logic [RT_WIDTH-1:0]      req_task_runtime,
   input  wire logic [PRIO_WIDTH-1:0]    req_task_priority,
   input  wire logic                     req_task_running,
   input  wire logic [SLICE_WIDTH-1:0]   req_slice_left,
   output      logic                     rsp_valid,
   output      logic [TASK_ID_WIDTH-1:0] rsp_next_task_id,
   output      logic                     rsp_switched,
   output      logic [SLICE_WIDTH-1:0]   rsp_slice_value,
   output      logic [LEN_W-1:0]         rsp_queue_count,
   output      logic                     rsp_overflow
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int SUM_W   = PTR_W + 1;
   localparam int ENTRY_W = TASK_ID_WIDTH + RT_WIDTH + PRIO_WIDTH;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : PTR_W'(p - PTR_W'(1));
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : PTR_W'(p + PTR_W'(1));
   endfunction

   vrq_state_type state_ff, state_in;

   logic [PTR_W-1:0]         head_ff, head_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [RUN_CNT_WIDTH-1:0] run_ff, run_in;
   logic                     op_ff, op_in;
   logic [TASK_ID_WIDTH-1:0] cur_id_ff, cur_id_in;
   logic [RT_WIDTH-1:0]      cur_rt_ff, cur_rt_in;
   logic [PRIO_WIDTH-1:0]    cur_prio_ff, cur_prio_in;
   logic                     cur_run_ff, cur_run_in;
   logic [SLICE_WIDTH-1:0]   slice_ff, slice_in;
   logic [TASK_ID_WIDTH-1:0] hid_ff, hid_in;
   logic [RT_WIDTH-1:0]      hrt_ff, hrt_in;
   logic [PRIO_WIDTH-1:0]    hprio_ff, hprio_in;
   logic [ENTRY_W-1:0]       ins_ff, ins_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [LEN_W-1:0]         k_ff, k_in;
   logic [TASK_ID_WIDTH-1:0] next_ff, next_in;
   logic                     sw_ff, sw_in;
   logic                     ovf_ff, ovf_in;

   logic                     ram_we;
   logic [PTR_W-1:0]         ram_waddr;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [PTR_W-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]       ram_rdata;

   logic [SUM_W-1:0]         tail_sum;
   logic [PTR_W-1:0]         tail;
   logic                     queue_full;
   logic                     take_head;
   logic                     requeue;
   logic                     walk_on;
   logic [RT_WIDTH-1:0]      rd_rt;
   logic [RT_WIDTH-1:0]      ins_rt;

   vrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Physical slot one past the last queued entry.
   assign tail_sum   = SUM_W'(head_ff) + SUM_W'(len_ff);
   assign tail       = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
   assign queue_full = (len_ff == LEN_W'(QUEUE_DEPTH));
   assign take_head  = (cur_rt_ff >= hrt_ff) || !cur_run_ff;
   assign requeue    = take_head ? (cur_run_ff && (cur_id_ff != '0)) : (hid_ff != '0);
   assign rd_rt      = ram_rdata[PRIO_WIDTH +: RT_WIDTH];
   assign ins_rt     = ins_ff[PRIO_WIDTH +: RT_WIDTH];
   assign walk_on    = (rd_rt >= ins_rt);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_INSERT) begin
                  state_in = ((req_task_id == '0) || queue_full) ? ST_DONE : ST_INS_RD;
               end else begin
                  state_in = (len_ff == '0) ? ST_DECIDE : ST_POP;
               end
            end
         end
         ST_POP:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = requeue ? ST_INS_RD : ST_DONE;
         ST_INS_RD: state_in = (k_ff == '0) ? ST_DONE : ST_INS_WR;
         ST_INS_WR: state_in = walk_on ? ST_INS_RD : ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      head_in     = head_ff;
      len_in      = len_ff;
      run_in      = run_ff;
      op_in       = op_ff;
      cur_id_in   = cur_id_ff;
      cur_rt_in   = cur_rt_ff;
      cur_prio_in = cur_prio_ff;
      cur_run_in  = cur_run_ff;
      slice_in    = slice_ff;
      hid_in      = hid_ff;
      hrt_in      = hrt_ff;
      hprio_in    = hprio_ff;
      ins_in      = ins_ff;
      wp_in       = wp_ff;
      k_in        = k_ff;
      next_in     = next_ff;
      sw_in       = sw_ff;
      ovf_in      = ovf_ff;
      ram_we      = 1'b0;
      ram_waddr   = wp_ff;
      ram_wdata   = ins_ff;
      ram_raddr   = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = req_opcode;
               cur_id_in   = req_task_id;
               cur_rt_in   = req_task_runtime;
               cur_prio_in = req_task_priority;
               cur_run_in  = req_task_running;
               slice_in    = req_slice_left;
               next_in     = '0;
               sw_in       = 1'b0;
               ovf_in      = (req_opcode == OP_INSERT) && (req_task_id != '0) && queue_full;
               ins_in      = {req_task_id, req_task_runtime, req_task_priority};
               k_in        = len_ff;
               wp_in       = tail;
               // An empty queue yields the idle task as head.
               hid_in      = '0;
               hrt_in      = cfg.idle_runtime;
               hprio_in    = cfg.idle_priority;
            end
         end
         ST_POP: begin
            hid_in   = ram_rdata[PRIO_WIDTH + RT_WIDTH +: TASK_ID_WIDTH];
            hrt_in   = rd_rt;
            hprio_in = ram_rdata[PRIO_WIDTH-1:0];
            head_in  = ptr_inc(head_ff);
            len_in   = LEN_W'(len_ff - LEN_W'(1));
            run_in   = RUN_CNT_WIDTH'(run_ff - RUN_CNT_WIDTH'(1));
         end
         ST_DECIDE: begin
            k_in  = len_ff;
            wp_in = tail;
            sw_in = take_head;
            if (take_head) begin
               next_in = hid_ff;
               ins_in  = {cur_id_ff, cur_rt_ff, cur_prio_ff};
            end else begin
               next_in = cur_id_ff;
               ins_in  = {hid_ff, hrt_ff, hprio_ff};
            end
         end
         ST_INS_RD: begin
            ram_raddr = ptr_dec(wp_ff);
            if (k_ff == '0) begin
               ram_we = 1'b1;
               len_in = LEN_W'(len_ff + LEN_W'(1));
               run_in = RUN_CNT_WIDTH'(run_ff + RUN_CNT_WIDTH'(1));
            end
         end
         ST_INS_WR: begin
            ram_we = 1'b1;
            if (walk_on) begin
               // The entry below is not smaller, so it moves up one slot.
               ram_wdata = ram_rdata;
               wp_in     = ptr_dec(wp_ff);
               k_in      = LEN_W'(k_ff - LEN_W'(1));
            end else begin
               len_in = LEN_W'(len_ff + LEN_W'(1));
               run_in = RUN_CNT_WIDTH'(run_ff + RUN_CNT_WIDTH'(1));
            end
         end
         ST_DONE: begin
            ram_we = 1'b0;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_DONE);
      rsp_next_task_id = next_ff;
      rsp_switched     = sw_ff;
      rsp_queue_count  = len_ff;
      rsp_overflow     = ovf_ff;
      if ((op_ff == OP_SCHEDULE) && (slice_ff == '0)) begin
         rsp_slice_value = slice_refill(run_ff, hprio_ff);
      end else begin
         rsp_slice_value = slice_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         len_ff   <= '0;
         run_ff   <= RUN_CNT_WIDTH'(1);
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         len_ff   <= len_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cur_id_ff   <= cur_id_in;
      cur_rt_ff   <= cur_rt_in;
      cur_prio_ff <= cur_prio_in;
      cur_run_ff  <= cur_run_in;
      slice_ff    <= slice_in;
      hid_ff      <= hid_in;
      hrt_ff      <= hrt_in;
      hprio_ff    <= hprio_in;
      ins_ff      <= ins_in;
      wp_ff       <= wp_in;
      k_ff        <= k_in;
      next_ff     <= next_in;
      sw_ff       <= sw_in;
      ovf_ff      <= ovf_in;
   end

endmodule

`default_nettype wire

// ===== dv/vruntime_run_queue_scheduler_unit_test.sv =====
// Self-checking testbench for vruntime_run_queue_scheduler_unit: drives insert and schedule items,
// writes the idle task registers between phases and checks every result against a built-in
// run queue predictor. Depends on vrq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module vruntime_run_queue_scheduler_unit_test;
   import vrq_pkg::*;

   localparam int QDEPTH = DEF_QUEUE_DEPTH;
   localparam int IDW = DEF_TASK_ID_WIDTH;
   localparam int LEN_W = $clog2(QDEPTH + 1);
   localparam logic [RT_WIDTH-1:0] RT_MAX = 63'h7fff_ffff_ffff_fffe;
   localparam logic [RT_WIDTH-1:0] RT_ALL = 63'h7fff_ffff_ffff_ffff;
   localparam int ITEMS_PER_PHASE = 633;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 2 * QDEPTH + 10;

   typedef struct packed {
      logic                   op;
      logic [IDW-1:0]         id;
      logic [RT_WIDTH-1:0]    rt;
      logic [PRIO_WIDTH-1:0]  prio;
      logic                   running;
      logic [SLICE_WIDTH-1:0] slice;
   } task_item_type;

   typedef struct packed {
      logic [IDW-1:0]         next_id;
      logic                   switched;
      logic [SLICE_WIDTH-1:0] slice;
      logic [LEN_W-1:0]       count;
      logic                   overflow;
   } decision_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = 1'b0;
   logic [IDW-1:0] req_task_id = '0;
   logic [RT_WIDTH-1:0] req_task_runtime = '0;
   logic [PRIO_WIDTH-1:0] req_task_priority = '0;
   logic req_task_running = 1'b0;
   logic [SLICE_WIDTH-1:0] req_slice_left = '0;
   logic rsp_valid;
   logic [IDW-1:0] rsp_next_task_id;
   logic rsp_switched;
   logic [SLICE_WIDTH-1:0] rsp_slice_value;
   logic [LEN_W-1:0] rsp_queue_count;
   logic rsp_overflow;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   vruntime_run_queue_scheduler_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_task_id(req_task_id),
      .req_task_runtime(req_task_runtime),
      .req_task_priority(req_task_priority),
      .req_task_running(req_task_running),
      .req_slice_left(req_slice_left),
      .rsp_valid(rsp_valid),
      .rsp_next_task_id(rsp_next_task_id),
      .rsp_switched(rsp_switched),
      .rsp_slice_value(rsp_slice_value),
      .rsp_queue_count(rsp_queue_count),
      .rsp_overflow(rsp_overflow),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // Predictor copy of the run queue and the idle task registers.
   logic [IDW-1:0] rq_id [QDEPTH];
   logic [RT_WIDTH-1:0] rq_rt [QDEPTH];
   logic [PRIO_WIDTH-1:0] rq_prio [QDEPTH];
   int rq_len = 0;
   logic [RUN_CNT_WIDTH-1:0] runnable = RUN_CNT_WIDTH'(1);
   logic [RT_WIDTH-1:0] cfg_idle_rt = '0;
   logic [PRIO_WIDTH-1:0] cfg_idle_prio = '0;

   task_item_type pending_items[$];
   decision_type expected_decisions[$];
   logic item_taken = 1'b0;
   int sender_idle_pct = 0;
   int fail_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int insert_pct = 50;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sorted insert: equal runtimes go in front of the entries already queued.
   function automatic bit rq_insert(input logic [IDW-1:0] id, input logic [RT_WIDTH-1:0] rt,
                                    input logic [PRIO_WIDTH-1:0] prio);
      int pos;
      int k;
      if (id == '0) return 1'b1;
      if (rq_len >= QDEPTH) return 1'b0;
      pos = 0;
      while (pos < rq_len && rq_rt[pos] < rt) pos++;
      for (k = rq_len; k > pos; k--) begin
         rq_id[k] = rq_id[k-1];
         rq_rt[k] = rq_rt[k-1];
         rq_prio[k] = rq_prio[k-1];
      end
      rq_id[pos] = id;
      rq_rt[pos] = rt;
      rq_prio[pos] = prio;
      rq_len++;
      runnable = runnable + RUN_CNT_WIDTH'(1);
      return 1'b1;
   endfunction

   function automatic decision_type schedule_decision(input task_item_type item);
      decision_type d;
      logic [IDW-1:0] hid;
      logic [RT_WIDTH-1:0] hrt;
      logic [PRIO_WIDTH-1:0] hprio;
      logic [SLICE_WIDTH-1:0] base;
      int cnt;
      int k;
      d = '0;
      d.slice = item.slice;
      if (item.op == OP_INSERT) begin
         d.overflow = !rq_insert(item.id, item.rt, item.prio);
      end else begin
         if (rq_len == 0) begin
            hid = '0;
            hrt = cfg_idle_rt;
            hprio = cfg_idle_prio;
         end else begin
            hid = rq_id[0];
            hrt = rq_rt[0];
            hprio = rq_prio[0];
            for (k = 1; k < rq_len; k++) begin
               rq_id[k-1] = rq_id[k];
               rq_rt[k-1] = rq_rt[k];
               rq_prio[k-1] = rq_prio[k];
            end
            rq_len--;
            runnable = runnable - RUN_CNT_WIDTH'(1);
         end
         if (item.rt >= hrt || !item.running) begin
            if (item.running) void'(rq_insert(item.id, item.rt, item.prio));
            d.next_id = hid;
            d.switched = 1'b1;
         end else begin
            void'(rq_insert(hid, hrt, hprio));
            d.next_id = item.id;
         end
         if (item.slice == '0) begin
            cnt = (runnable == '0) ? 1 : int'(runnable);
            base = SLICE_WIDTH'(4 / cnt);
            d.slice = (hprio <= 1) ? base : SLICE_WIDTH'(base * 3);
         end
      end
      d.count = LEN_W'(rq_len);
      return d;
   endfunction

   function automatic task_item_type task_item(input logic op, input logic [IDW-1:0] id,
                                               input logic [RT_WIDTH-1:0] rt,
                                               input logic [PRIO_WIDTH-1:0] prio,
                                               input logic running,
                                               input logic [SLICE_WIDTH-1:0] slice);
      task_item_type item;
      item.op = op;
      item.id = id;
      item.rt = rt;
      item.prio = prio;
      item.running = running;
      item.slice = slice;
      return item;
   endfunction

   // Bursts with a changing insert share let the queue both fill up to overflow and drain empty.
   function automatic task_item_type random_item();
      task_item_type item;
      logic [63:0] wide;
      int pick;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 8);
         pick = $urandom_range(2);
         insert_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 85;
      end
      burst_left--;
      item.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_SCHEDULE;
      pick = $urandom_range(99);
      item.id = (pick < 8) ? '0 : (pick < 13) ? '1 : IDW'($urandom_range(255, 1));
      pick = $urandom_range(99);
      wide = {$urandom, $urandom};
      if (pick < 40) item.rt = RT_WIDTH'($urandom_range(15));
      else if (pick < 65) item.rt = wide[RT_WIDTH-1:0];
      else if (pick < 75) item.rt = wide[0] ? RT_MAX : '0;
      else item.rt = cfg_idle_rt - RT_WIDTH'(2) + RT_WIDTH'($urandom_range(4));
      if (item.rt == RT_ALL) item.rt = RT_MAX;
      item.prio = PRIO_WIDTH'($urandom_range(3));
      item.running = ($urandom_range(99) < 80);
      pick = $urandom_range(99);
      item.slice = (pick < 40) ? '0 : (pick < 45) ? '1 : SLICE_WIDTH'($urandom_range(255, 1));
      return item;
   endfunction

   // APB register write with a setup and an access phase; the predictor copy follows at the access edge.
   task automatic write_csr(input logic reg_sel, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == REG_IDLE_RUNTIME) cfg_idle_rt = value[RT_WIDTH-1:0];
      else cfg_idle_prio = value[PRIO_WIDTH-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (expected_decisions.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         fail_count++;
         if (mismatch_count < 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // Driver: holds an item until it is taken, then offers the next one or idles.
   always @(negedge clock) begin
      task_item_type item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            item = pending_items.pop_front();
            start <= 1'b1;
            req_opcode <= item.op;
            req_task_id <= item.id;
            req_task_runtime <= item.rt;
            req_task_priority <= item.prio;
            req_task_running <= item.running;
            req_slice_left <= item.slice;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each result, then records the item taken at this edge.
   always @(posedge clock) begin
      decision_type d;
      if (reset) begin
         item_taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_decisions.size() == 0) begin
               fail_count++;
               if (mismatch_count < 40)
                  $display("%0t: result with no item outstanding, expected none, actual id %0d",
                           $time, rsp_next_task_id);
               mismatch_count++;
            end else begin
               d = expected_decisions.pop_front();
               check_field("next_task_id", 64'(d.next_id), 64'(rsp_next_task_id));
               check_field("switched", 64'(d.switched), 64'(rsp_switched));
               check_field("slice_value", 64'(d.slice), 64'(rsp_slice_value));
               check_field("queue_count", 64'(d.count), 64'(rsp_queue_count));
               check_field("overflow", 64'(d.overflow), 64'(rsp_overflow));
            end
         end
         item_taken = start && !busy;
         if (item_taken)
            expected_decisions.push_back(schedule_decision(task_item(req_opcode, req_task_id,
               req_task_runtime, req_task_priority, req_task_running, req_slice_left)));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int i;
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: idle task with the largest runtime and priority.
      write_csr(REG_IDLE_RUNTIME, 64'(RT_ALL));
      write_csr(REG_IDLE_PRIORITY, 64'(3));
      sender_idle_pct = 34;
      // Empty queue: a current task below the idle runtime keeps running.
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd7, 63'd5, 2'd1, 1'b1, 8'd0));
      // A stopped current task always switches, here to the idle task.
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd0, RT_MAX, 2'd0, 1'b0, 8'd9));
      pending_items.push_back(task_item(OP_INSERT, 8'd0, RT_MAX, 2'd3, 1'b1, 8'd33));
      pending_items.push_back(task_item(OP_INSERT, 8'd9, 63'd500, 2'd2, 1'b0, 8'd0));
      // Head is requeued without a switch.
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd8, 63'd1, 2'd0, 1'b1, 8'd0));
      pending_items.push_back(task_item(OP_INSERT, 8'd255, RT_MAX, 2'd3, 1'b1, 8'd255));
      for (i = 1; i <= 14; i++)
         pending_items.push_back(task_item(OP_INSERT, IDW'(i), RT_WIDTH'((i % 3) * 500),
                                           PRIO_WIDTH'(i % 4), 1'b1, SLICE_WIDTH'(i)));
      // The queue is full now, so this insert is dropped.
      pending_items.push_back(task_item(OP_INSERT, 8'd128, 63'd0, 2'd0, 1'b1, 8'd1));
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd50, 63'd0, 2'd2, 1'b1, 8'd0));
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd51, RT_MAX, 2'd3, 1'b0, 8'd0));
      pending_items.push_back(task_item(OP_SCHEDULE, 8'd0, RT_MAX, 2'd1, 1'b1, 8'd255));
      wait_quiet();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_csr(REG_IDLE_RUNTIME, 64'd0);
               write_csr(REG_IDLE_PRIORITY, 64'd0);
               sender_idle_pct = 34;
            end
            1: begin
               write_csr(REG_IDLE_RUNTIME, {1'b0, 31'($urandom), 32'($urandom)});
               write_csr(REG_IDLE_PRIORITY, 64'($urandom_range(3)));
               sender_idle_pct = 85;
            end
            default: begin
               write_csr(REG_IDLE_RUNTIME, 64'd8);
               write_csr(REG_IDLE_PRIORITY, 64'd2);
               sender_idle_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) pending_items.push_back(random_item());
         wait_quiet();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/vrq_pkg.sv
rtl/vrq_ram.sv
rtl/vrq_csr.sv
rtl/vrq_ctrl.sv
rtl/vruntime_run_queue_scheduler_unit.sv
dv/vruntime_run_queue_scheduler_unit_test.sv
